/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define BPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on every rising edge, reset included
`define BPC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

/* rtl/bpc_pkg.sv */
`timescale 1ns / 1ps

package bpc_pkg;

    // field widths
    localparam int RAW_W  = 24;
    localparam int CAL_W  = 16;
    localparam int TEMP_W = 15;
    localparam int PRES_W = 17;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // number of register stages from input word to result word
    localparam int N_STAGE = 9;

    // temperature knees and output ranges
    localparam int TEMP_BASE = 2000;
    localparam int TEMP_KNEE = 1500;
    localparam int TEMP_MIN  = -4000;
    localparam int TEMP_MAX  = 8500;
    localparam int PRES_MAX  = 131071;

    // calibration register map, word index = byte address / 4
    typedef enum logic [2:0] {
        REG_SENS     = 3'd0,
        REG_OFF      = 3'd1,
        REG_SENS_TC  = 3'd2,
        REG_OFF_TC   = 3'd3,
        REG_TREF     = 3'd4,
        REG_TEMPSENS = 3'd5
    } t_reg_idx;

endpackage

/* rtl/bpc_if.sv */
`timescale 1ns / 1ps

// raw conversion pair
interface bpc_smp_if;
    logic                         valid;
    logic                         ready;
    logic [bpc_pkg::RAW_W-1:0]    raw_pressure;
    logic [bpc_pkg::RAW_W-1:0]    raw_temperature;

    modport source (output valid, raw_pressure, raw_temperature, input ready);
    modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

// compensated result
interface bpc_res_if;
    logic                            valid;
    logic                            ready;
    logic signed [bpc_pkg::TEMP_W-1:0] temperature_centi;
    logic [bpc_pkg::PRES_W-1:0]      pressure_pa;
    logic                            saturated;

    modport source (output valid, temperature_centi, pressure_pa, saturated, input ready);
    modport sink (input valid, temperature_centi, pressure_pa, saturated, output ready);
endinterface

/* rtl/baro_pressure_temp_compensation.sv */
`timescale 1ns / 1ps
// path: an accepted sample word passes the stage registers a to i in order to its result word on o_res
// throughput: one word per cycle; each of the nine stages holds one word and
//   moves it on whenever the stage ahead is empty or moving, so a stall on
//   o_res fills the bubbles before i_smp.ready drops
// reset: synchronous, active low; empties the pipeline and clears the six
//   calibration words to zero
module baro_pressure_temp_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]    paddr,
    input  logic [bpc_pkg::DATA_W-1:0]    pwdata,
    output logic [bpc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    bpc_smp_if.sink                       i_smp,
    bpc_res_if.source                     o_res
);

    localparam int NS = bpc_pkg::N_STAGE;

    // rounding biases for truncating signed shifts toward zero
    localparam logic signed [41:0] T_BIAS    = 42'sd8388607;
    localparam logic signed [41:0] OFF_BIAS  = 42'sd127;
    localparam logic signed [41:0] SENS_BIAS = 42'sd255;

    // calibration words
    logic [bpc_pkg::CAL_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    // stage handshake
    logic [NS-1:0] r_vld;
    logic [NS:0]   w_adv;

    // stage a: dT
    logic [bpc_pkg::RAW_W-1:0] r_a_d1;
    logic signed [24:0]        r_a_dt;
    // stage b: products of dT
    logic [bpc_pkg::RAW_W-1:0] r_b_d1;
    logic signed [41:0]        r_b_pt, r_b_poff, r_b_psens;
    logic [47:0]               r_b_pdd;
    // stage c: first-order terms
    logic [bpc_pkg::RAW_W-1:0] r_c_d1;
    logic signed [18:0]        r_c_temp;
    logic signed [39:0]        r_c_off, r_c_sens;
    logic [16:0]               r_c_t2;
    // stage d: squares for second order
    logic [bpc_pkg::RAW_W-1:0] r_d_d1;
    logic [33:0]               r_d_sqd, r_d_sqe;
    logic                      r_d_lo, r_d_vlo;
    logic signed [19:0]        r_d_temp;
    logic signed [39:0]        r_d_off, r_d_sens;
    // stage e: corrected offset and sensitivity, clipped temperature
    logic [bpc_pkg::RAW_W-1:0] r_e_d1;
    logic signed [39:0]        r_e_off, r_e_sens;
    logic signed [bpc_pkg::TEMP_W-1:0] r_e_temp;
    logic                      r_e_tsat;
    // stage f: partial products of D1 * SENS
    logic [43:0]               r_f_plo;
    logic signed [44:0]        r_f_phi;
    logic signed [39:0]        r_f_off;
    logic signed [bpc_pkg::TEMP_W-1:0] r_f_temp;
    logic                      r_f_tsat;
    // stage g: full product
    logic signed [63:0]        r_g_prod;
    logic signed [39:0]        r_g_off;
    logic signed [bpc_pkg::TEMP_W-1:0] r_g_temp;
    logic                      r_g_tsat;
    // stage h: D1*SENS/2^21 - OFF
    logic signed [43:0]        r_h_q;
    logic signed [bpc_pkg::TEMP_W-1:0] r_h_temp;
    logic                      r_h_tsat;
    // stage i: result word
    logic signed [bpc_pkg::TEMP_W-1:0] r_i_temp;
    logic [bpc_pkg::PRES_W-1:0] r_i_pres;
    logic                      r_i_sat;

    // apb port
    logic w_wr;
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        case (paddr[bpc_pkg::ADDR_W-1:2])
            bpc_pkg::REG_SENS:     prdata = {16'b0, r_c1};
            bpc_pkg::REG_OFF:      prdata = {16'b0, r_c2};
            bpc_pkg::REG_SENS_TC:  prdata = {16'b0, r_c3};
            bpc_pkg::REG_OFF_TC:   prdata = {16'b0, r_c4};
            bpc_pkg::REG_TREF:     prdata = {16'b0, r_c5};
            bpc_pkg::REG_TEMPSENS: prdata = {16'b0, r_c6};
            default:               prdata = '0;
        endcase
    end

    // a stage moves on when it is empty or the stage ahead moves
    always_comb begin
        w_adv[NS] = o_res.ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign i_smp.ready = w_adv[0];

    // control state and calibration words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_c1  <= '0;
            r_c2  <= '0;
            r_c3  <= '0;
            r_c4  <= '0;
            r_c5  <= '0;
            r_c6  <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_smp.valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
            if (w_wr) begin
                case (paddr[bpc_pkg::ADDR_W-1:2])
                    bpc_pkg::REG_SENS:     r_c1 <= pwdata[bpc_pkg::CAL_W-1:0];
                    bpc_pkg::REG_OFF:      r_c2 <= pwdata[bpc_pkg::CAL_W-1:0];
                    bpc_pkg::REG_SENS_TC:  r_c3 <= pwdata[bpc_pkg::CAL_W-1:0];
                    bpc_pkg::REG_OFF_TC:   r_c4 <= pwdata[bpc_pkg::CAL_W-1:0];
                    bpc_pkg::REG_TREF:     r_c5 <= pwdata[bpc_pkg::CAL_W-1:0];
                    bpc_pkg::REG_TEMPSENS: r_c6 <= pwdata[bpc_pkg::CAL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // stage a: dT = D2 - C5*2^8
    logic signed [24:0] n_a_dt;
    assign n_a_dt = $signed({1'b0, i_smp.raw_temperature}) - $signed({1'b0, r_c5, 8'b0});

    // stage b: the four products of dT
    logic signed [41:0] n_b_pt, n_b_poff, n_b_psens;
    logic signed [49:0] w_dd;
    assign n_b_pt    = r_a_dt * $signed({1'b0, r_c6});
    assign n_b_poff  = r_a_dt * $signed({1'b0, r_c4});
    assign n_b_psens = r_a_dt * $signed({1'b0, r_c3});
    assign w_dd      = r_a_dt * r_a_dt;

    // stage c: TEMP, OFF, SENS and T2
    logic signed [41:0] w_pt_b, w_poff_b, w_psens_b;
    logic signed [18:0] n_c_temp;
    logic signed [39:0] n_c_off, n_c_sens;
    always_comb begin
        w_pt_b    = r_b_pt + (r_b_pt[41] ? T_BIAS : 42'sd0);
        w_poff_b  = r_b_poff + (r_b_poff[41] ? OFF_BIAS : 42'sd0);
        w_psens_b = r_b_psens + (r_b_psens[41] ? SENS_BIAS : 42'sd0);
        n_c_temp  = $signed(w_pt_b[41:23]) + 19'(bpc_pkg::TEMP_BASE);
        n_c_off   = 40'($signed(w_poff_b[41:7])) + $signed({8'b0, r_c2, 16'b0});
        n_c_sens  = 40'($signed(w_psens_b[41:8])) + $signed({9'b0, r_c1, 15'b0});
    end

    // stage d: squares of the distance to each knee
    logic signed [18:0] w_dtemp, w_etemp;
    logic signed [37:0] w_sqd, w_sqe;
    assign w_dtemp = r_c_temp - 19'(bpc_pkg::TEMP_BASE);
    assign w_etemp = r_c_temp + 19'(bpc_pkg::TEMP_KNEE);
    assign w_sqd   = w_dtemp * w_dtemp;
    assign w_sqe   = w_etemp * w_etemp;

    // stage e: OFF2, SENS2 and temperature clip
    logic [36:0] w_5d, w_7e;
    logic [37:0] w_11e, w_off2, w_sens2;
    logic signed [39:0] n_e_off, n_e_sens;
    logic signed [bpc_pkg::TEMP_W-1:0] n_e_temp;
    logic n_e_tsat;
    always_comb begin
        w_5d   = {3'b0, r_d_sqd} + {1'b0, r_d_sqd, 2'b0};
        w_7e   = {r_d_sqe, 3'b0} - {3'b0, r_d_sqe};
        w_11e  = {1'b0, r_d_sqe, 3'b0} + {3'b0, r_d_sqe, 1'b0} + {4'b0, r_d_sqe};
        w_off2 = '0;
        w_sens2 = '0;
        if (r_d_lo) begin
            w_off2  = 38'(w_5d[36:1]) + (r_d_vlo ? 38'(w_7e) : 38'd0);
            w_sens2 = 38'(w_5d[36:2]) + (r_d_vlo ? 38'(w_11e[37:1]) : 38'd0);
        end
        n_e_off  = r_d_off - $signed({2'b0, w_off2});
        n_e_sens = r_d_sens - $signed({2'b0, w_sens2});
        n_e_tsat = 1'b0;
        if (r_d_temp < 20'(bpc_pkg::TEMP_MIN)) begin
            n_e_temp = bpc_pkg::TEMP_W'(bpc_pkg::TEMP_MIN);
            n_e_tsat = 1'b1;
        end else if (r_d_temp > 20'(bpc_pkg::TEMP_MAX)) begin
            n_e_temp = bpc_pkg::TEMP_W'(bpc_pkg::TEMP_MAX);
            n_e_tsat = 1'b1;
        end else begin
            n_e_temp = r_d_temp[bpc_pkg::TEMP_W-1:0];
        end
    end

    // stage f: D1 times low and high halves of SENS
    logic [43:0]        n_f_plo;
    logic signed [44:0] n_f_phi;
    assign n_f_plo = r_e_d1 * r_e_sens[19:0];
    assign n_f_phi = $signed({1'b0, r_e_d1}) * $signed(r_e_sens[39:20]);

    // stage g: recombine the halves
    logic signed [64:0] w_prod;
    assign w_prod = $signed({r_f_phi, 20'b0}) + $signed({21'b0, r_f_plo});

    // stage h: truncating shift folded into the subtract as a carry
    logic               w_hcorr;
    logic signed [43:0] n_h_q;
    assign w_hcorr = r_g_prod[63] && (|r_g_prod[20:0]);
    assign n_h_q   = 44'($signed(r_g_prod[63:21])) - 44'(r_g_off)
                     + $signed({43'b0, w_hcorr});

    // stage i: final shift and pressure clip
    logic               w_icorr;
    logic signed [28:0] w_pq;
    logic [bpc_pkg::PRES_W-1:0] n_i_pres;
    logic               n_i_psat;
    always_comb begin
        w_icorr  = r_h_q[43] && (|r_h_q[14:0]);
        w_pq     = $signed(r_h_q[43:15]) + $signed({28'b0, w_icorr});
        n_i_psat = 1'b0;
        if (w_pq < 29'sd0) begin
            n_i_pres = '0;
            n_i_psat = 1'b1;
        end else if (w_pq > 29'(bpc_pkg::PRES_MAX)) begin
            n_i_pres = bpc_pkg::PRES_W'(bpc_pkg::PRES_MAX);
            n_i_psat = 1'b1;
        end else begin
            n_i_pres = w_pq[bpc_pkg::PRES_W-1:0];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_a_d1 <= i_smp.raw_pressure;
            r_a_dt <= n_a_dt;
        end
        if (w_adv[1]) begin
            r_b_d1    <= r_a_d1;
            r_b_pt    <= n_b_pt;
            r_b_poff  <= n_b_poff;
            r_b_psens <= n_b_psens;
            r_b_pdd   <= w_dd[47:0];
        end
        if (w_adv[2]) begin
            r_c_d1   <= r_b_d1;
            r_c_temp <= n_c_temp;
            r_c_off  <= n_c_off;
            r_c_sens <= n_c_sens;
            r_c_t2   <= r_b_pdd[47:31];
        end
        if (w_adv[3]) begin
            r_d_d1   <= r_c_d1;
            r_d_sqd  <= w_sqd[33:0];
            r_d_sqe  <= w_sqe[33:0];
            r_d_lo   <= r_c_temp < 19'(bpc_pkg::TEMP_BASE);
            r_d_vlo  <= r_c_temp < 19'(-bpc_pkg::TEMP_KNEE);
            // T2 only taken off below the upper knee
            r_d_temp <= 20'(r_c_temp) - ((r_c_temp < 19'(bpc_pkg::TEMP_BASE))
                        ? $signed({3'b0, r_c_t2}) : 20'sd0);
            r_d_off  <= r_c_off;
            r_d_sens <= r_c_sens;
        end
        if (w_adv[4]) begin
            r_e_d1   <= r_d_d1;
            r_e_off  <= n_e_off;
            r_e_sens <= n_e_sens;
            r_e_temp <= n_e_temp;
            r_e_tsat <= n_e_tsat;
        end
        if (w_adv[5]) begin
            r_f_plo  <= n_f_plo;
            r_f_phi  <= n_f_phi;
            r_f_off  <= r_e_off;
            r_f_temp <= r_e_temp;
            r_f_tsat <= r_e_tsat;
        end
        if (w_adv[6]) begin
            r_g_prod <= w_prod[63:0];
            r_g_off  <= r_f_off;
            r_g_temp <= r_f_temp;
            r_g_tsat <= r_f_tsat;
        end
        if (w_adv[7]) begin
            r_h_q    <= n_h_q;
            r_h_temp <= r_g_temp;
            r_h_tsat <= r_g_tsat;
        end
        if (w_adv[8]) begin
            r_i_temp <= r_h_temp;
            r_i_pres <= n_i_pres;
            r_i_sat  <= r_h_tsat || n_i_psat;
        end
    end

    // result word
    assign o_res.valid             = r_vld[NS-1];
    assign o_res.temperature_centi = r_i_temp;
    assign o_res.pressure_pa       = r_i_pres;
    assign o_res.saturated         = r_i_sat;

endmodule

/* rtl/bpc_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [bpc_pkg::TEMP_W-1:0]   i_out_temp,
    input logic [bpc_pkg::PRES_W-1:0]          i_out_pres,
    input logic                                i_out_sat
);

    // words accepted but not yet delivered
    logic [3:0] r_cnt;
    logic [3:0] n_cnt;
    logic       w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;
    assign n_cnt     = r_cnt + 4'(w_in_acc) - 4'(w_out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // a stalled result word holds
    `BPC_ASSERT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_temp) && $stable(i_out_pres) && $stable(i_out_sat), "result word changed under stall")

    // temperature stays inside its clip range
    `BPC_ASSERT(a_temp_rng, i_clk, i_rst_n, i_out_valid |-> (i_out_temp >= 15'(bpc_pkg::TEMP_MIN)) && (i_out_temp <= 15'(bpc_pkg::TEMP_MAX)), "temperature outside clip range")

    // never more words in flight than pipeline stages
    `BPC_ASSERT(a_depth, i_clk, i_rst_n, r_cnt <= 4'(bpc_pkg::N_STAGE), "more words in flight than stages")

    // no result word without an accepted sample behind it
    `BPC_ASSERT(a_no_phantom, i_clk, i_rst_n, i_out_valid |-> r_cnt != 4'd0, "result word with nothing in flight")

    // reset empties the pipeline
    `BPC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind baro_pressure_temp_compensation bpc_checker u_bpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_temp  (o_res.temperature_centi),
    .i_out_pres  (o_res.pressure_pa),
    .i_out_sat   (o_res.saturated)
);
